### hdl/rspg_pkg.sv
// ----------------------------------------------------------------------------
// rspg_pkg: shared types and helpers for the road scanline pixel generator
// Holds the group geometry, field widths, opcodes and the per-pixel
// road step and pixel coding functions used by the lanes and the merger.
// ----------------------------------------------------------------------------
package rspg_pkg;

  localparam int unsigned GroupPixels = 8;
  localparam int unsigned PenEntries  = 64;
  localparam int unsigned RoadW       = 6;
  localparam int unsigned PenW        = 4;
  localparam int unsigned PixelW      = 7;
  localparam int unsigned ScrollW     = 3;
  localparam int unsigned StepW       = 3;
  localparam int unsigned InDataW     = 40;
  localparam int unsigned OutDataW    = GroupPixels * PixelW;

  localparam logic [PixelW-1:0] PixelBase = 7'h40;

  // item kind carried in tuser
  typedef enum logic {
    OpWritePen = 1'b0,
    OpGroup    = 1'b1
  } opcode_e;

  // control of the item sitting in the read stage
  typedef struct packed {
    logic               valid;
    logic               is_group;
    logic               first_group;
    logic [ScrollW-1:0] line_scroll;
  } stage_t;

  // one road step: two plane bits, bumped by one when nonzero and carry enabled
  function automatic logic [StepW-1:0] road_step(input logic lo_bit, input logic hi_bit,
                                                 input logic carry_off);
    logic [StepW-1:0] step;
    step = {1'b0, hi_bit, lo_bit};
    if (!carry_off && (step != '0)) begin
      step = step + 3'd1;
    end
    return step;
  endfunction

  // output pixel code from a pen
  function automatic logic [PixelW-1:0] pixel_code(input logic [PenW-1:0] pen);
    return PixelBase | {{(PixelW-PenW){1'b0}}, pen};
  endfunction

endpackage

### hdl/rspg_lane.sv
// ----------------------------------------------------------------------------
// rspg_lane: one pixel lane of the road generator
// Sums the road steps ahead of its pixel, forms the pen table address and
// reads its own copy of the pen table into a registered pen.
// ----------------------------------------------------------------------------
module rspg_lane #(
  parameter int unsigned Lane = 0
) (
  input  logic                       clk_i,
  input  logic                       rd_en_i,
  input  logic                       wr_en_i,
  input  logic [rspg_pkg::RoadW-1:0] wr_addr_i,
  input  logic [rspg_pkg::PenW-1:0]  wr_data_i,
  input  logic                       off_road_i,
  input  logic [7:0]                 control_byte_i,
  input  logic [7:0]                 bits_low_i,
  input  logic [7:0]                 bits_high_i,
  output logic [rspg_pkg::PenW-1:0]  pen_o
);

  logic [rspg_pkg::PenW-1:0]  pen_mem_q [rspg_pkg::PenEntries];
  logic [rspg_pkg::PenW-1:0]  pen_q;
  logic [rspg_pkg::RoadW-1:0] offset;
  logic [rspg_pkg::RoadW-1:0] rd_addr;

  // prefix sum of the steps before this pixel; the leftmost step reads bit 8,
  // which is always clear, so it is left out
  always_comb begin
    offset = '0;
    for (int j = 1; j < Lane; j++) begin
      offset = offset + {3'b000, rspg_pkg::road_step(bits_low_i[rspg_pkg::GroupPixels - j],
                                                     bits_high_i[rspg_pkg::GroupPixels - j],
                                                     control_byte_i[7])};
    end
    if (off_road_i) begin
      rd_addr = '0;
    end else begin
      rd_addr = control_byte_i[rspg_pkg::RoadW-1:0] + offset;
    end
  end

  // local copy of the pen table
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      pen_mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      pen_q <= pen_mem_q[rd_addr];
    end
  end

  assign pen_o = pen_q;

endmodule

### hdl/rspg_merge.sv
// ----------------------------------------------------------------------------
// rspg_merge: joins lane pens with the previous group under fine scroll
// Keeps the previous group's pens and the line scroll, and drives the
// output word register toward the master side.
// ----------------------------------------------------------------------------
module rspg_merge (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  rspg_pkg::stage_t                                  stage_i,
  input  logic [rspg_pkg::GroupPixels-1:0][rspg_pkg::PenW-1:0] cur_pens_i,
  input  logic                                              m_axis_tready,
  output logic                                              m_axis_tvalid,
  output logic [rspg_pkg::OutDataW-1:0]                     m_axis_tdata,
  output logic                                              advance_o
);

  logic [rspg_pkg::GroupPixels-1:0][rspg_pkg::PenW-1:0]   prev_pens_q;
  logic [rspg_pkg::ScrollW-1:0]                           scroll_q;
  logic                                                   out_valid_q, out_valid_d;
  logic [rspg_pkg::GroupPixels-1:0][rspg_pkg::PixelW-1:0] out_data_q, out_data_d;
  logic [2*rspg_pkg::GroupPixels-1:0][rspg_pkg::PenW-1:0] joined;
  logic                                                   produces;
  logic                                                   retire_group;
  logic [rspg_pkg::ScrollW:0]                             src;

  // a group that is not the first of its line makes one word
  assign produces     = stage_i.valid && stage_i.is_group && !stage_i.first_group;
  assign advance_o    = !produces || !out_valid_q || m_axis_tready;
  assign retire_group = stage_i.valid && stage_i.is_group && advance_o;
  assign joined       = {cur_pens_i, prev_pens_q};

  // scroll window over previous and current group
  always_comb begin
    src = '0;
    for (int k = 0; k < rspg_pkg::GroupPixels; k++) begin
      src           = 4'(k) + {1'b0, scroll_q};
      out_data_d[k] = rspg_pkg::pixel_code(joined[src]);
    end
  end

  // output word handshake
  always_comb begin
    out_valid_d = out_valid_q;
    if (produces && advance_o) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      prev_pens_q <= '0;
      scroll_q    <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      if (retire_group) begin
        prev_pens_q <= cur_pens_i;
        if (stage_i.first_group) begin
          scroll_q <= stage_i.line_scroll;
        end
      end
    end
  end

  // output word payload
  always_ff @(posedge clk_i) begin
    if (produces && advance_o) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

### hdl/road_scanline_pixel_generator.sv
// ----------------------------------------------------------------------------
// road_scanline_pixel_generator: eight-pixel road scanline generator
// Turns pen writes and road groups into words of eight pixel codes.
// ----------------------------------------------------------------------------
// Slave side: one word per item. tuser is the opcode; a pen write loads one
// pen table entry, a group carries the control byte and two bit planes or
// the off-road flag. Master side: one word of eight 7-bit pixel codes per
// group that is not the first of its line; pen writes and first groups
// give no word.
// Eight lanes each hold a copy of the pen table and read one pixel's pen;
// a merge stage joins them with the previous group under the line scroll.
// A word passes the lane table read register, then the output register.
// Throughput: one item per cycle unless the receiver stalls, set by the
// single read port of each lane's table copy.
// Reset clears the previous group pens, the scroll and all valid flags; the
// pen table is undefined until written.
// When the receiver stalls, the output word holds and the read stage holds
// one more item; tready drops once both are full.
// ----------------------------------------------------------------------------
module road_scanline_pixel_generator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // pen_index[5:0], pen_value[9:6], first_group[10], line_scroll[13:11],
  // off_road[14], control_byte[22:15], bits_low[30:23], bits_high[38:31]
  input  logic [rspg_pkg::InDataW-1:0]      s_axis_tdata,
  // opcode[0]
  input  logic [0:0]                        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // pixel_0[6:0], pixel_1[13:7], ... pixel_7[55:49]
  output logic [rspg_pkg::OutDataW-1:0]     m_axis_tdata
);

  rspg_pkg::stage_t s1_q, s1_d;
  logic             accept;
  logic             advance;
  logic             is_group;
  logic             wr_en;
  logic             rd_en;
  logic [rspg_pkg::GroupPixels-1:0][rspg_pkg::PenW-1:0] cur_pens;

  // input word fields
  logic [5:0] pen_index;
  logic [3:0] pen_value;
  logic       first_group;
  logic [2:0] line_scroll;
  logic       off_road;
  logic [7:0] control_byte;
  logic [7:0] bits_low;
  logic [7:0] bits_high;

  assign pen_index    = s_axis_tdata[5:0];
  assign pen_value    = s_axis_tdata[9:6];
  assign first_group  = s_axis_tdata[10];
  assign line_scroll  = s_axis_tdata[13:11];
  assign off_road     = s_axis_tdata[14];
  assign control_byte = s_axis_tdata[22:15];
  assign bits_low     = s_axis_tdata[30:23];
  assign bits_high    = s_axis_tdata[38:31];

  // handshake
  assign s_axis_tready = !s1_q.valid || advance;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign is_group      = (s_axis_tuser[0] == rspg_pkg::OpGroup);
  assign wr_en         = accept && (s_axis_tuser[0] == rspg_pkg::OpWritePen);
  assign rd_en         = accept && is_group;

  // read stage control
  always_comb begin
    s1_d = s1_q;
    if (s_axis_tready) begin
      s1_d.valid       = accept;
      s1_d.is_group    = is_group;
      s1_d.first_group = first_group;
      s1_d.line_scroll = line_scroll;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
    end else begin
      s1_q <= s1_d;
    end
  end

  // pixel lanes
  for (genvar g = 0; g < rspg_pkg::GroupPixels; g++) begin : g_lane
    rspg_lane #(
      .Lane(g)
    ) u_lane (
      .clk_i          (clk_i),
      .rd_en_i        (rd_en),
      .wr_en_i        (wr_en),
      .wr_addr_i      (pen_index),
      .wr_data_i      (pen_value),
      .off_road_i     (off_road),
      .control_byte_i (control_byte),
      .bits_low_i     (bits_low),
      .bits_high_i    (bits_high),
      .pen_o          (cur_pens[g])
    );
  end

  // merge and output register
  rspg_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .stage_i       (s1_q),
    .cur_pens_i    (cur_pens),
    .m_axis_tready (m_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tdata  (m_axis_tdata),
    .advance_o     (advance)
  );

  // a stalled input means the read stage is occupied
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> s1_q.valid)
    else $error("input stalled with empty read stage");

  // items that make no word never wait on the receiver
  a_no_word_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_q.valid && (!s1_q.is_group || s1_q.first_group)) |-> advance)
    else $error("item without a word held in read stage");

  // the first and last output pixels carry the road pixel base
  a_pixel_base: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[6:4] == 3'b100) && (m_axis_tdata[55:53] == 3'b100))
    else $error("output pixel outside road pen range");

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: stream testbench for the road scanline pixel generator
// Fills the pen table, then runs directed groups covering the scroll,
// carry and off-road corners, then random scanlines with pen writes and
// noise mixed in. A scoreboard predicts every pixel word and compares it
// with the output stream. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned TotalItems  = 1300;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned MaxReports  = 100;
  localparam logic [rspg_pkg::PixelW-1:0] PixelOffset = 7'h40;

  // input word layout, lowest field last
  typedef struct packed {
    logic         pad;
    logic [7:0]   bits_high;
    logic [7:0]   bits_low;
    logic [7:0]   control_byte;
    logic         off_road;
    logic [2:0]   line_scroll;
    logic         first_group;
    logic [3:0]   pen_value;
    logic [5:0]   pen_index;
  } road_item_t;

  // predicts pixel words from accepted items and checks the output stream
  class road_pixel_scoreboard;
    logic [rspg_pkg::PenW-1:0]     pen_table [rspg_pkg::PenEntries];
    logic [rspg_pkg::PenW-1:0]     prev_pens [rspg_pkg::GroupPixels];
    logic [rspg_pkg::ScrollW-1:0]  scroll;
    logic [rspg_pkg::OutDataW-1:0] expected_words [$];
    int unsigned                   errors;

    function new();
      foreach (pen_table[i]) pen_table[i] = '0;
      foreach (prev_pens[i]) prev_pens[i] = '0;
      scroll = '0;
      errors = 0;
    endfunction

    task report(input string msg);
      errors++;
      if (errors <= MaxReports) $display("mismatch: %s", msg);
    endtask

    function int unsigned pending();
      return expected_words.size();
    endfunction

    function void note_input(input rspg_pkg::opcode_e op, input road_item_t it);
      logic [rspg_pkg::PenW-1:0]     cur [rspg_pkg::GroupPixels];
      logic [rspg_pkg::RoadW-1:0]    road;
      logic [2:0]                    step;
      logic [rspg_pkg::OutDataW-1:0] word;
      int unsigned                   src;
      if (op == rspg_pkg::OpWritePen) begin
        pen_table[it.pen_index] = it.pen_value;
        return;
      end
      // pens of this group, left to right
      road = it.control_byte[5:0];
      for (int k = 0; k < rspg_pkg::GroupPixels; k++) begin
        if (it.off_road) begin
          cur[k] = pen_table[0];
        end else begin
          // leftmost step reads plane bit 8, which does not exist
          if (k == 0) step = 3'd0;
          else step = {1'b0, it.bits_high[8-k], it.bits_low[8-k]};
          if (!it.control_byte[7] && step != 3'd0) step = step + 3'd1;
          cur[k] = pen_table[road];
          road = road + {3'b000, step};
        end
      end
      // first group only primes the line
      if (it.first_group) begin
        scroll = it.line_scroll;
        prev_pens = cur;
        return;
      end
      // join previous and current group under the scroll
      for (int k = 0; k < rspg_pkg::GroupPixels; k++) begin
        src = k + scroll;
        word[k*rspg_pkg::PixelW +: rspg_pkg::PixelW] = PixelOffset |
          {3'b000, (src < rspg_pkg::GroupPixels) ? prev_pens[src]
                                                 : cur[src-rspg_pkg::GroupPixels]};
      end
      expected_words.push_back(word);
      prev_pens = cur;
    endfunction

    task check_word(input logic [rspg_pkg::OutDataW-1:0] word);
      logic [rspg_pkg::OutDataW-1:0] want;
      if (expected_words.size() == 0) begin
        report($sformatf("unexpected word %h", word));
        return;
      end
      want = expected_words.pop_front();
      for (int k = 0; k < rspg_pkg::GroupPixels; k++) begin
        if (word[k*rspg_pkg::PixelW +: rspg_pkg::PixelW] !==
            want[k*rspg_pkg::PixelW +: rspg_pkg::PixelW])
          report($sformatf("pixel_%0d got %h want %h", k,
                           word[k*rspg_pkg::PixelW +: rspg_pkg::PixelW],
                           want[k*rspg_pkg::PixelW +: rspg_pkg::PixelW]));
      end
    endtask
  endclass

  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [rspg_pkg::InDataW-1:0]  s_axis_tdata  = '0;
  logic [0:0]                    s_axis_tuser  = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [rspg_pkg::OutDataW-1:0] m_axis_tdata;

  road_pixel_scoreboard sb = new();
  int unsigned item_count  = 0;
  int unsigned cycle_count = 0;
  int unsigned tx_idle_pct = 50;
  int unsigned rx_idle_pct = 50;

  road_scanline_pixel_generator u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic int unsigned draw_gap(input int unsigned pct);
    return ($urandom_range(0, 99) < pct) ? $urandom_range(0, 8) : 0;
  endfunction

  function automatic int unsigned pick_idle();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 40;
      default: return 100;
    endcase
  endfunction

  function automatic road_item_t random_item();
    logic [63:0] r;
    road_item_t  it;
    r = {$urandom, $urandom};
    it = r[rspg_pkg::InDataW-1:0];
    it.pad = 1'b0;
    return it;
  endfunction

  // push one word into the slave side and wait for its handshake
  task automatic send_item(input rspg_pkg::opcode_e op, input road_item_t it);
    int unsigned gap;
    gap = draw_gap(tx_idle_pct);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= it;
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_input(op, it);
    item_count++;
  endtask

  task automatic write_pen(input logic [5:0] idx, input logic [3:0] val);
    road_item_t it;
    it = random_item();
    it.pen_index = idx;
    it.pen_value = val;
    send_item(rspg_pkg::OpWritePen, it);
  endtask

  task automatic send_group(input logic first, input logic [2:0] scr, input logic off,
                            input logic [7:0] ctrl, input logic [7:0] lo,
                            input logic [7:0] hi);
    road_item_t it;
    it = random_item();
    it.first_group  = first;
    it.line_scroll  = scr;
    it.off_road     = off;
    it.control_byte = ctrl;
    it.bits_low     = lo;
    it.bits_high    = hi;
    send_item(rspg_pkg::OpGroup, it);
  endtask

  task automatic send_random_group(input logic first);
    road_item_t it;
    it = random_item();
    it.first_group = first;
    it.off_road    = ($urandom_range(0, 4) == 0);
    send_item(rspg_pkg::OpGroup, it);
  endtask

  // master side: stall at random, check each word taken
  initial begin
    int unsigned gap;
    forever begin
      gap = draw_gap(rx_idle_pct);
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      sb.check_word(m_axis_tdata);
    end
  end

  // stimulus
  initial begin
    int unsigned n_groups;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // group before any first group joins the zero pens at scroll zero
    write_pen(6'd0, 4'($urandom_range(0, 15)));
    send_group(1'b0, 3'd0, 1'b1, 8'h00, 8'h00, 8'h00);
    for (int i = 1; i < rspg_pkg::PenEntries - 1; i++)
      write_pen(6'(i), 4'($urandom_range(0, 15)));
    write_pen(6'd63, 4'd15);

    // directed corners: full planes, carry on and off, wrap, off-road, scrolls
    send_group(1'b1, 3'd0, 1'b0, 8'h00, 8'hff, 8'hff);
    send_group(1'b0, 3'd0, 1'b0, 8'h3f, 8'hff, 8'hff);
    send_group(1'b0, 3'd0, 1'b0, 8'h80, 8'haa, 8'h55);
    send_group(1'b0, 3'd0, 1'b1, 8'hff, 8'h00, 8'h00);
    send_group(1'b1, 3'd7, 1'b0, 8'hbf, 8'h00, 8'hff);
    send_group(1'b0, 3'd0, 1'b0, 8'h7f, 8'h01, 8'h80);
    send_group(1'b0, 3'd5, 1'b1, 8'h40, 8'hff, 8'hff);
    write_pen(6'd0, 4'd0);
    send_group(1'b0, 3'd0, 1'b1, 8'h00, 8'hff, 8'h00);
    send_group(1'b1, 3'd3, 1'b0, 8'hc1, 8'h3c, 8'hc3);
    send_group(1'b1, 3'd5, 1'b0, 8'h2a, 8'hf0, 8'h0f);
    send_group(1'b0, 3'd0, 1'b0, 8'h15, 8'h81, 8'h7e);
    write_pen(6'd0, 4'd15);
    send_group(1'b0, 3'd2, 1'b1, 8'hc0, 8'hfe, 8'hfe);

    // random scanlines, with pen writes and noise between them
    while (item_count < TotalItems) begin
      tx_idle_pct = pick_idle();
      rx_idle_pct = pick_idle();
      case ($urandom_range(0, 9))
        0: begin
          repeat ($urandom_range(1, 4))
            send_item(rspg_pkg::opcode_e'($urandom_range(0, 1)), random_item());
        end
        1: begin
          repeat ($urandom_range(1, 4)) write_pen(6'($urandom_range(0, 63)),
                                                  4'($urandom_range(0, 15)));
        end
        default: begin
          send_random_group(1'b1);
          n_groups = $urandom_range(1, 12);
          repeat (n_groups) begin
            if ($urandom_range(0, 9) == 0)
              write_pen(6'($urandom_range(0, 63)), 4'($urandom_range(0, 15)));
            send_random_group(1'b0);
          end
        end
      endcase
    end
    s_axis_tvalid <= 1'b0;

    // drain
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
